// ===== rtl/multi_timer_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the timer table
// Shared assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef MULTI_TIMER_TABLE_TOP_DEFINES_SVH
`define MULTI_TIMER_TABLE_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define MTT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MTT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer table package
// Action codes, status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package mtt_pkg;

	typedef enum logic [2:0] {
		ACT_ADD_ONCE     = 3'd0,
		ACT_ADD_REPEAT   = 3'd1,
		ACT_CANCEL_ID    = 3'd2,
		ACT_CANCEL_OWNER = 3'd3,
		ACT_SET_PAUSE    = 3'd4,
		ACT_TICK         = 3'd5,
		ACT_CLEAR        = 3'd6,
		ACT_COUNT        = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ZERO_PERIOD = 2'd1,
		ST_FULL        = 2'd2,
		ST_NOT_FOUND   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_SCAN = 5'b00100,
		S_SORT = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] id;
		logic        fired;
		logic [6:0]  count;
		logic        last;
	} result_t;

endpackage

// ===== rtl/multi_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// Timer table
// Table of one-shot and repeating timers kept in a slot memory.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  request  | in        | req_valid / req_stall | action .. global_pause
//  response | out       | rsp_valid / rsp_stall | status, result_id, fired, count, last
//
// Add, clear and a globally paused tick pass exec and emit to set rsp_valid.
// Cancel, pause and count sweep the slot memory once.
// A tick sweeps once to update, then again for each fired timer to pick the lowest
// id, and once more to find none left and send its last response; the single read
// port reads the slots one at a time.
// Reset clears the live bits and sets the id counter to 1; the slot memory is not cleared.
// A stalled response holds the sequencer in its emit state; req_stall is high
// whenever the sequencer is not idle.
// ----------------------------------------------------------------------------
`include "multi_timer_table_top_defines.svh"

module multi_timer_table_top #(
	parameter int SLOTS     = 16,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  action,
	input  logic [31:0] duration,
	input  logic        has_owner,
	input  logic [31:0] owner,
	input  logic [31:0] timer_id,
	input  logic        pause_value,
	input  logic [31:0] elapsed,
	input  logic        global_pause,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [31:0] result_id,
	output logic        fired,
	output logic [6:0]  count,
	output logic        last
);
	import mtt_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int TB = TIME_BITS;
	localparam int MW = (TB > 32) ? TB : 32;
	localparam logic [TB-1:0] TMAX = '1;
	localparam result_t RES_DONE = '{status: ST_OK, id: '0, fired: 1'b0, count: '0,
		last: 1'b1};

	typedef struct packed {
		logic [31:0]      ident;
		logic [TB-1:0]    period;
		logic signed [TB:0] left;
		logic             repeats;
		logic             held;
		logic             owned;
		logic [31:0]      owner;
	} slot_t;

	function automatic logic [TB-1:0] clamp_time(input logic [31:0] v);
		logic [MW-1:0] w;
		w = MW'(v);
		if (w > MW'(TMAX))
			return TMAX;
		return w[TB-1:0];
	endfunction

	// Request registers
	action_t       act_q;
	logic [TB-1:0] dur_q;
	logic          own_flag_q;
	logic [31:0]   owner_q;
	logic [31:0]   tid_q;
	logic          pv_q;
	logic [TB-1:0] el_q;
	logic          gp_q;

	state_t         state_q;
	logic [CW-1:0]  idx_q;
	logic           rv_s1;
	logic [IW-1:0]  ra_s1;
	logic [SLOTS-1:0] live_q;
	logic [SLOTS-1:0] fire_q;
	logic           found_q;
	logic [CW-1:0]  cnt_q;
	logic [31:0]    best_id_q;
	logic [IW-1:0]  best_idx_q;
	logic           have_q;
	logic [31:0]    next_id_q;
	result_t        res_q;
	result_t        out_q;
	logic           rsp_valid_q;
	logic           emit_go;

	// Slot memory, one read and one write port
	slot_t         mem [SLOTS];
	slot_t         rd_s1;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	slot_t         mem_wd;
	logic          mem_re;
	logic [IW-1:0] mem_ra;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_s1 <= mem[mem_ra];
	end

	// Lowest free slot
	logic          free_any;
	logic [IW-1:0] free_idx;
	always_comb begin
		free_any = ~&live_q;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (!live_q[i])
				free_idx = IW'(i);
	end

	logic add_zero;
	assign add_zero = (act_q == ACT_ADD_REPEAT) && (dur_q == '0);

	// Tick arithmetic on the entry just read
	logic signed [TB:0] sub_v;
	logic signed [TB:0] add_v;
	logic               expire;
	logic               id_hit;
	logic               scan_live;
	always_comb begin
		sub_v     = rd_s1.left - $signed({1'b0, el_q});
		add_v     = sub_v + $signed({1'b0, rd_s1.period});
		expire    = (sub_v <= 0);
		id_hit    = !found_q && (rd_s1.ident == tid_q);
		scan_live = (state_q == S_SCAN) && rv_s1 && live_q[ra_s1];
	end

	assign mem_re = ((state_q == S_SCAN) || (state_q == S_SORT)) && (idx_q < CW'(SLOTS));
	assign mem_ra = idx_q[IW-1:0];
	assign emit_go = (state_q == S_EMIT) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ra_s1;
		mem_wd = rd_s1;
		if ((state_q == S_EXEC) && free_any && !add_zero &&
		    ((act_q == ACT_ADD_ONCE) || (act_q == ACT_ADD_REPEAT))) begin
			mem_we         = 1'b1;
			mem_wa         = free_idx;
			mem_wd.ident   = next_id_q;
			mem_wd.period  = dur_q;
			mem_wd.left    = $signed({1'b0, dur_q});
			mem_wd.repeats = (act_q == ACT_ADD_REPEAT);
			mem_wd.held    = 1'b0;
			mem_wd.owned   = own_flag_q;
			mem_wd.owner   = owner_q;
		end else if (scan_live && (act_q == ACT_SET_PAUSE) && id_hit) begin
			mem_we      = 1'b1;
			mem_wd.held = pv_q;
		end else if (scan_live && (act_q == ACT_TICK) && !rd_s1.held) begin
			mem_we      = 1'b1;
			mem_wd.left = sub_v;
			// A repeating timer keeps its overshoot unless that leaves it expired.
			if (expire && rd_s1.repeats)
				mem_wd.left = (add_v <= 0) ? $signed({1'b0, rd_s1.period}) : add_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			rv_s1       <= 1'b0;
			live_q      <= '0;
			fire_q      <= '0;
			found_q     <= 1'b0;
			cnt_q       <= '0;
			have_q      <= 1'b0;
			next_id_q   <= 32'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit_go)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			rv_s1 <= mem_re;
			ra_s1 <= mem_ra;
			if (mem_re)
				idx_q <= idx_q + 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						act_q      <= action_t'(action);
						dur_q      <= clamp_time(duration);
						own_flag_q <= has_owner;
						owner_q    <= owner;
						tid_q      <= timer_id;
						pv_q       <= pause_value;
						el_q       <= clamp_time(elapsed);
						gp_q       <= global_pause;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					cnt_q   <= '0;
					fire_q  <= '0;
					unique case (act_q)
						ACT_ADD_ONCE, ACT_ADD_REPEAT: begin
							state_q <= S_EMIT;
							if (add_zero) begin
								res_q <= '{status: ST_ZERO_PERIOD, id: '0, fired: 1'b0,
								           count: '0, last: 1'b1};
							end else if (!free_any) begin
								res_q <= '{status: ST_FULL, id: '0, fired: 1'b0,
								           count: '0, last: 1'b1};
							end else begin
								live_q[free_idx] <= 1'b1;
								res_q <= '{status: ST_OK, id: next_id_q, fired: 1'b0,
								           count: '0, last: 1'b1};
								next_id_q <= (next_id_q == '1) ? 32'd1 : next_id_q + 32'd1;
							end
						end
						ACT_CLEAR: begin
							live_q  <= '0;
							res_q   <= RES_DONE;
							state_q <= S_EMIT;
						end
						ACT_TICK: begin
							res_q   <= RES_DONE;
							state_q <= gp_q ? S_EMIT : S_SCAN;
						end
						ACT_CANCEL_ID, ACT_CANCEL_OWNER, ACT_SET_PAUSE, ACT_COUNT:
							state_q <= S_SCAN;
					endcase
				end
				S_SCAN: begin
					if (scan_live) begin
						unique case (act_q)
							ACT_CANCEL_ID: begin
								if (id_hit) begin
									live_q[ra_s1] <= 1'b0;
									found_q       <= 1'b1;
								end
							end
							ACT_SET_PAUSE: begin
								if (id_hit)
									found_q <= 1'b1;
							end
							ACT_CANCEL_OWNER: begin
								if (rd_s1.owned && (rd_s1.owner == owner_q)) begin
									live_q[ra_s1] <= 1'b0;
									cnt_q         <= cnt_q + 1'b1;
								end
							end
							ACT_COUNT: cnt_q <= cnt_q + 1'b1;
							ACT_TICK: begin
								if (!rd_s1.held && expire) begin
									fire_q[ra_s1] <= 1'b1;
									if (!rd_s1.repeats)
										live_q[ra_s1] <= 1'b0;
								end
							end
							ACT_ADD_ONCE, ACT_ADD_REPEAT, ACT_CLEAR: ;
						endcase
					end
					if (!mem_re && !rv_s1) begin
						res_q <= '{status: ((((act_q == ACT_CANCEL_ID) ||
						                      (act_q == ACT_SET_PAUSE)) && !found_q) ?
						                    ST_NOT_FOUND : ST_OK),
						           id: '0, fired: 1'b0, count: 7'(cnt_q), last: 1'b1};
						if (act_q == ACT_TICK) begin
							idx_q   <= '0;
							have_q  <= 1'b0;
							state_q <= S_SORT;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_SORT: begin
					// Strict compare keeps the lowest slot among equal ids.
					if (rv_s1 && fire_q[ra_s1] && (!have_q || (rd_s1.ident < best_id_q))) begin
						have_q     <= 1'b1;
						best_id_q  <= rd_s1.ident;
						best_idx_q <= ra_s1;
					end
					if (!mem_re && !rv_s1) begin
						res_q   <= '{status: ST_OK, id: (have_q ? best_id_q : 32'd0),
						             fired: have_q, count: '0, last: !have_q};
						state_q <= S_EMIT;
						if (have_q)
							fire_q[best_idx_q] <= 1'b0;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_q   <= res_q;
						idx_q   <= '0;
						have_q  <= 1'b0;
						state_q <= res_q.last ? S_IDLE : S_SORT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status    = out_q.status;
	assign result_id = out_q.id;
	assign fired     = out_q.fired;
	assign count     = out_q.count;
	assign last      = out_q.last;

	`MTT_ASSERT(a_no_write_idle, (state_q == S_IDLE) |-> !mem_we, "slot write while idle")
	`MTT_ASSERT(a_read_in_sweep, rv_s1 |-> (state_q == S_SCAN || state_q == S_SORT), "stray read")
	`MTT_ASSERT(a_fired_not_last, (rsp_valid && fired) |-> (!last && status == ST_OK), "bad fired")
	`MTT_ASSERT_ALWAYS(a_id_nonzero, arst_n |-> (next_id_q != '0), "next id is zero")

endmodule
